// ===== rtl/core/ets_pkg.sv =====
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types and constants for the eased tween stepper.
// ----------------------------------------------------------------------------
`default_nettype none
package ets_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE  = 2'd0,
    REG_DUR   = 2'd1,
    REG_START = 2'd2,
    REG_END   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    EASE_LINEAR = 2'd0,
    EASE_IN_OUT = 2'd1,
    EASE_IN     = 2'd2,
    EASE_OUT    = 2'd3
  } ease_mode_e;

  localparam logic signed [31:0] SinCoef [6] = '{
    32'sd1686629713, -32'sd693598668, 32'sd85569274,
    -32'sd5026995, 32'sd172273, -32'sd3864
  };

  typedef struct packed {
    logic restart;
  } tick_req_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic        still_moving;
  } tick_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/ets_if.sv =====
// ----------------------------------------------------------------------------
// ets_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface ets_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/eased_tween_stepper.sv =====
// ----------------------------------------------------------------------------
// eased_tween_stepper
// Per-tick tween generator with linear and sine easing curves.
// ----------------------------------------------------------------------------
// operation: a request is taken, then a 32-step restoring divide, then
// 32-step shift-add multiplies (square, five polynomial steps, final x
// step and the value scale for the sine curves; only the value scale
// for linear mode); zero duration goes straight to the result
// throughput: one request at a time; the next is taken only after the
// result is taken
// reset: count, registers and handshake clear; no memory to sweep
`default_nettype none
module eased_tween_stepper
  import ets_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  ets_if.sink                      req_if,
  ets_if.source                    rsp_if
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_PREP, S_SQ, S_HORN, S_ADD, S_LAST, S_ROUND,
    S_EASE, S_MUL, S_OUT
  } state_e;

  state_e state_q;
  logic [1:0]  mode_q;
  logic [15:0] dur_q, cnt_q;
  logic signed [31:0] start_q, end_q;
  logic [31:0] quo_q;
  logic [15:0] rem_q;
  logic [4:0]  bit_q;
  logic [5:0]  step_q;
  logic [2:0]  k_q;
  logic [16:0] r_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] mcand_q;
  logic [31:0] mplier_q;
  logic        mneg_q;
  logic signed [63:0] x2_q, x30_q, p_q;
  logic [16:0] e_q;
  logic        phase_q;
  logic        mov_q;
  logic        out_v_q;
  tick_rsp_t   out_q;
  logic signed [63:0] s_q;

  assign req_if.ready = (state_q == S_IDLE) && !out_v_q;
  assign rsp_if.valid = out_v_q;
  assign rsp_if.data  = out_q;

  logic [16:0] rem_sh;
  logic [17:0] rem_sub;
  always_comb begin
    rem_sh  = {rem_q, quo_q[31]};
    rem_sub = {1'b0, rem_sh} - {2'b0, dur_q};
  end

  // truncating divide by 2^30 (toward zero)
  function automatic logic signed [63:0] tdiv30(input logic signed [63:0] v);
    logic signed [63:0] a;
    a = v < 0 ? -v : v;
    a = a >>> 30;
    return v < 0 ? -a : a;
  endfunction

  logic [16:0] sin_in;
  always_comb begin
    sin_in = r_q;
    case (ease_mode_e'(mode_q))
      EASE_IN_OUT: sin_in = (r_q <= 17'd32768) ? 17'(17'd65536 - {r_q[15:0], 1'b0})
                                                : 17'({r_q[15:0], 1'b0} - 17'd65536);
      EASE_IN:     sin_in = 17'(17'd65536 - r_q);
      default:     sin_in = r_q;
    endcase
  end

  logic signed [63:0] rnd;
  always_comb begin
    rnd = (p_q < 0) ? 64'sd0 : ((p_q + 64'sd8192) >>> 14);
    if (rnd > 64'sd65536) rnd = 64'sd65536;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= '0; dur_q <= '0; start_q <= '0; end_q <= '0; cnt_q <= '0;
      out_v_q <= 1'b0;
      quo_q <= '0; rem_q <= '0; bit_q <= '0; step_q <= '0; k_q <= '0;
      r_q <= '0; acc_q <= '0; mcand_q <= '0; mplier_q <= '0; mneg_q <= 1'b0;
      x2_q <= '0; x30_q <= '0; p_q <= '0; e_q <= '0; phase_q <= 1'b0;
      mov_q <= 1'b0; out_q <= '0; s_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_MODE:  mode_q <= cfg_wdata_i[1:0];
          REG_DUR:   dur_q <= cfg_wdata_i[15:0];
          REG_START: start_q <= cfg_wdata_i;
          REG_END:   end_q <= cfg_wdata_i;
          default:   ;
        endcase
      end
      if (rsp_if.valid && rsp_if.ready) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: if (req_if.valid && req_if.ready) begin
          logic [15:0] c;
          c = req_if.data.restart ? 16'd0 : cnt_q;
          c = (c < dur_q) ? 16'(c + 16'd1) : dur_q;
          cnt_q <= c;
          mov_q <= c < dur_q;
          quo_q <= {c, 16'd0};
          rem_q <= '0;
          bit_q <= 5'd0;
          if (dur_q == 16'd0) begin
            out_q <= '{value_out: start_q, still_moving: 1'b0};
            state_q <= S_OUT;
          end else state_q <= S_DIV;
        end
        // restoring divide of c*65536 by duration, one quotient bit per cycle
        S_DIV: begin
          // dividend shifts out the top as quotient bits shift in below
          if (!rem_sub[17]) rem_q <= rem_sub[15:0];
          else rem_q <= rem_sh[15:0];
          quo_q <= {quo_q[30:0], !rem_sub[17]};
          bit_q <= bit_q + 5'd1;
          if (bit_q == 5'd31) state_q <= S_PREP;
        end
        S_PREP: begin
          r_q <= quo_q[16:0];
          state_q <= S_EASE;
          phase_q <= 1'b0;
        end
        S_EASE: begin
          if (!phase_q) begin
            if (ease_mode_e'(mode_q) == EASE_LINEAR) begin
              e_q <= r_q; mcand_q <= 64'(end_q) - 64'(start_q);
              mplier_q <= 32'(r_q); acc_q <= '0; step_q <= '0;
              state_q <= S_MUL;
            end else begin
              x30_q <= 64'(sin_in) <<< 14;
              mcand_q <= 64'(sin_in) <<< 14;
              mplier_q <= {1'b0, sin_in, 14'b0};
              acc_q <= '0; step_q <= '0; state_q <= S_SQ;
            end
          end else begin
            logic signed [63:0] s;
            s = rnd;
            case (ease_mode_e'(mode_q))
              EASE_IN_OUT: e_q <= (r_q <= 17'd32768) ? 17'((64'sd65536 - s) >>> 1)
                                                      : 17'((64'sd65536 + s) >>> 1);
              EASE_IN:     e_q <= 17'(64'sd65536 - s);
              default:     e_q <= 17'(s);
            endcase
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          mcand_q <= 64'(end_q) - 64'(start_q);
          mplier_q <= 32'(e_q); acc_q <= '0; step_q <= '0;
          state_q <= S_MUL;
        end
        // shift-add multiply, one multiplier bit per cycle
        S_SQ, S_HORN, S_LAST, S_MUL: begin
          if (mplier_q[0]) acc_q <= acc_q + mcand_q;
          mcand_q <= mcand_q <<< 1;
          mplier_q <= mplier_q >> 1;
          step_q <= step_q + 6'd1;
          if (step_q == 6'd31) begin
            logic signed [63:0] pr, t;
            pr = mplier_q[0] ? acc_q + mcand_q : acc_q;
            case (state_q)
              S_SQ: begin
                x2_q <= tdiv30(pr); p_q <= 64'(SinCoef[5]); k_q <= 3'd4;
                state_q <= S_ADD;
              end
              S_HORN: begin
                t = (mneg_q ? -tdiv30(pr) : tdiv30(pr)) + 64'(SinCoef[k_q]);
                p_q <= t;
                if (k_q == 3'd0) k_q <= 3'd7;
                else k_q <= k_q - 3'd1;
                state_q <= S_ADD;
              end
              S_LAST: begin
                p_q <= mneg_q ? -tdiv30(pr) : tdiv30(pr);
                phase_q <= 1'b1; state_q <= S_EASE;
              end
              default: begin
                s_q <= 64'(start_q) + (pr >>> 16);
                state_q <= S_OUT;
              end
            endcase
          end
        end
        // load next multiply: |p| times x2 (or x30 after last coefficient)
        S_ADD: begin
          logic signed [63:0] ap;
          ap = p_q < 0 ? -p_q : p_q;
          mneg_q <= p_q < 0;
          acc_q <= '0; step_q <= '0;
          if (k_q == 3'd7) begin
            mcand_q <= x30_q; mplier_q <= 32'(ap); state_q <= S_LAST;
          end else begin
            mcand_q <= x2_q; mplier_q <= 32'(ap); state_q <= S_HORN;
          end
        end
        S_OUT: begin
          if (dur_q != 16'd0) out_q <= '{value_out: s_q[31:0], still_moving: mov_q};
          out_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_eased_tween_stepper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eased_tween_stepper
// Drives tick requests and register writes into the tween stepper, keeps a
// fixed-point model of the tick count and easing curves, and checks every
// returned value and moving flag in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_eased_tween_stepper;
  import ets_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 120;
  localparam longint Q16One = 64'sd65536;
  localparam longint Q30One = 64'sd1073741824;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  ets_if #(.payload_t(tick_req_t)) req_if ();
  ets_if #(.payload_t(tick_rsp_t)) rsp_if ();

  eased_tween_stepper i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_if     (req_if),
    .rsp_if     (rsp_if)
  );

  // model state
  ease_mode_e  mdl_mode;
  logic [15:0] mdl_dur;
  logic [31:0] mdl_start;
  logic [31:0] mdl_end;
  logic [15:0] mdl_count;

  tick_rsp_t   pending_ticks[$];
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  int unsigned ticks_sent;
  bit          idle_en;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_eased_tween_stepper NOT OK");
      $finish;
    end
  end

  function automatic longint sin_q16(longint x);
    longint x30, x2, p;
    x30 = x * 16384;
    x2 = (x30 * x30) / Q30One;
    p = longint'(SinCoef[5]);
    for (int k = 4; k >= 0; k--) begin
      p = (p * x2) / Q30One + longint'(SinCoef[k]);
    end
    p = (p * x30) / Q30One;
    if (p < 0) p = 0;
    p = (p + 8192) / 16384;
    if (p > Q16One) p = Q16One;
    return p;
  endfunction

  function automatic longint ease_q16(ease_mode_e mode, longint r);
    case (mode)
      EASE_IN_OUT: begin
        if (r <= 32768) return (Q16One - sin_q16(Q16One - 2 * r)) / 2;
        return (Q16One + sin_q16(2 * r - Q16One)) / 2;
      end
      EASE_IN:  return Q16One - sin_q16(Q16One - r);
      EASE_OUT: return sin_q16(r);
      default:  return r;
    endcase
  endfunction

  function automatic tick_rsp_t tween_step(logic restart);
    tick_rsp_t rsp;
    longint r, e, s, d, val;
    if (restart) mdl_count = '0;
    if (mdl_count < mdl_dur) mdl_count = mdl_count + 1'b1;
    else mdl_count = mdl_dur;
    s = longint'($signed(mdl_start));
    if (mdl_dur == 0) begin
      rsp.value_out = mdl_start;
      rsp.still_moving = 1'b0;
    end else begin
      r = (longint'(mdl_count) * Q16One) / longint'(mdl_dur);
      e = ease_q16(mdl_mode, r);
      d = longint'($signed(mdl_end)) - s;
      val = s + ((d * e) >>> 16);
      rsp.value_out = val[31:0];
      rsp.still_moving = mdl_count < mdl_dur;
    end
    return rsp;
  endfunction

  // response side: check, then decide ready for the next edge
  always @(posedge clk_i or negedge rst_ni) begin
    tick_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_ticks.size() == 0) begin
          $error("result with no request outstanding: value_out %h", rsp_if.data.value_out);
          error_cnt++;
        end else begin
          want = pending_ticks.pop_front();
          if (rsp_if.data.value_out !== want.value_out) begin
            $error("value_out expected %h actual %h", want.value_out, rsp_if.data.value_out);
            error_cnt++;
          end
          if (rsp_if.data.still_moving !== want.still_moving) begin
            $error("still_moving expected %b actual %b", want.still_moving,
                   rsp_if.data.still_moving);
            error_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !(idle_en && ($urandom_range(99) < 28));
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_MODE:  mdl_mode = ease_mode_e'(data[1:0]);
      REG_DUR:   mdl_dur = data[15:0];
      REG_START: mdl_start = data;
      REG_END:   mdl_end = data;
      default: ;
    endcase
  endtask

  // the upper data bits of narrow registers are driven random
  task automatic configure(ease_mode_e mode, logic [15:0] dur, logic [31:0] s,
                           logic [31:0] e);
    write_reg(REG_MODE, {30'($urandom), mode});
    write_reg(REG_DUR, {16'($urandom), dur});
    write_reg(REG_START, s);
    write_reg(REG_END, e);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_tick(logic restart);
    int unsigned gap;
    gap = (idle_en && ($urandom_range(99) < 28)) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data.restart <= restart;
    do @(posedge clk_i); while (!req_if.ready);
    pending_ticks.push_back(tween_step(restart));
    ticks_sent++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    send_tick(1'b0);
    send_tick(1'b1);
    drain();
  endtask

  task automatic test_directed();
    configure(EASE_LINEAR, 16'd4, 32'h8000_0000, 32'h7fff_ffff);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    drain();
    configure(EASE_IN_OUT, 16'd3, 32'h7fff_ffff, 32'h8000_0000);
    repeat (4) send_tick(1'b0);
    drain();
    configure(EASE_IN, 16'hffff, 32'hffff_ffff, 32'h7fff_ffff);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();
    configure(EASE_OUT, 16'd2, 32'h0001_0000, 32'hfff0_0000);
    repeat (3) send_tick(1'b0);
    drain();
    // duration cut below the running count
    configure(EASE_IN_OUT, 16'd10, 32'h0, 32'h0100_0000);
    repeat (4) send_tick(1'b0);
    drain();
    write_reg(REG_DUR, 32'd2);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_tick(1'b0);
    drain();
    configure(EASE_OUT, 16'd0, 32'h1234_5678, 32'h8765_4321);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    configure(EASE_IN, 16'd6, 32'($urandom), 32'($urandom));
    hold_left = 400;
    repeat (12) send_tick($urandom_range(3) == 0);
    drain();
  endtask

  task automatic test_random();
    int unsigned phase, n;
    logic [15:0] dur;
    phase = 0;
    while (ticks_sent < 1050) begin
      idle_en = !(phase >= 8 && phase < 14);
      case ($urandom_range(9))
        0:       dur = 16'hffff;
        1:       dur = 16'($urandom);
        2:       dur = 16'd0;
        default: dur = 16'($urandom_range(1, 24));
      endcase
      configure(ease_mode_e'($urandom_range(3)), dur,
                ($urandom_range(4) == 0) ? 32'h8000_0000 : 32'($urandom),
                ($urandom_range(4) == 0) ? 32'h7fff_ffff : 32'($urandom));
      n = $urandom_range(5, 40);
      repeat (n) send_tick($urandom_range(9) == 0);
      drain();
      phase++;
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_MODE;
    cfg_wdata_i  = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    error_cnt    = 0;
    cycle_cnt    = 0;
    ticks_sent   = 0;
    idle_en      = 1'b1;
    hold_left    = 0;
    mdl_mode     = EASE_LINEAR;
    mdl_dur      = '0;
    mdl_start    = '0;
    mdl_end      = '0;
    mdl_count    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_backpressure();
    test_random();
    if (error_cnt == 0) begin
      $display("tb_eased_tween_stepper OK");
    end else begin
      $display("tb_eased_tween_stepper NOT OK");
    end
    $finish;
  end

endmodule
